### hdl/sgpl_pkg.sv
// Shared types and constants for the stereo gain ramp peak limiter.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package sgpl_pkg;

    // Field widths
    localparam int SAMPLE_W = 24;
    localparam int FRAMES_W = 13;
    localparam int GAIN_W   = 19;
    localparam int STEP_W   = 20;
    localparam int RAMP_W   = 8;
    localparam int CEIL_W   = 27;
    localparam int HOLD_W   = 16;
    localparam int COEF_W   = 24;
    localparam int ADDR_W   = 2;
    localparam int DATA_W   = 24;

    // Reciprocal divider: quotient bits, divisor bits, steps per division
    localparam int QUO_W     = 27;
    localparam int DEN_W     = 24;
    localparam int DIV_STEPS = 27;
    localparam int CNT_W     = 5;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] REG_TARGET_GAIN   = 2'd0;
    localparam logic [ADDR_W-1:0] REG_HOLD_FRAMES   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_RELEASE_COEFF = 2'd2;
    localparam logic [ADDR_W-1:0] REG_MONO_OUTPUT   = 2'd3;

    // Reset values
    localparam logic [GAIN_W-1:0] TARGET_GAIN_RST   = 19'd65536;
    localparam logic [HOLD_W-1:0] HOLD_FRAMES_RST   = 16'd2400;
    localparam logic [COEF_W-1:0] RELEASE_COEFF_RST = 24'd2913;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch_in;
        logic prep;
        logic div_step;
        logic update;
        logic rel_lo;
        logic rel_hi;
        logic rel_sum;
        logic rel_commit;
        logic mul_left;
        logic mul_right;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
    } t_dp_status;

endpackage

### hdl/sgpl_if.sv
// Valid/ready channel interfaces: input frame, output frame, register write.
// Depends on sgpl_pkg for field widths.
interface sgpl_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sgpl_pkg::SAMPLE_W-1:0]   left_sample;
    logic signed [sgpl_pkg::SAMPLE_W-1:0]   right_sample;
    logic                                   block_start;
    logic [sgpl_pkg::FRAMES_W-1:0]          block_frames;

    modport source (output valid, left_sample, right_sample, block_start, block_frames,
                    input ready);
    modport sink (input valid, left_sample, right_sample, block_start, block_frames,
                  output ready);
endinterface

interface sgpl_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [sgpl_pkg::SAMPLE_W-1:0]   out_left;
    logic signed [sgpl_pkg::SAMPLE_W-1:0]   out_right;

    modport source (output valid, out_left, out_right, input ready);
    modport sink (input valid, out_left, out_right, output ready);
endinterface

interface sgpl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [sgpl_pkg::ADDR_W-1:0]    addr;
    logic [sgpl_pkg::DATA_W-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

### hdl/stereo_gain_ramp_peak_limiter_top.sv
// Top level of the stereo gain ramp peak limiter.
// Depends on sgpl_pkg and sgpl_if; instantiates sgpl_ctrl and sgpl_dp.
//
// Usage:
//   i_in   takes one stereo frame per request: left_sample, right_sample (Q1.23),
//          block_start and block_frames. A block start begins a linear gain ramp
//          toward the target gain over min(block_frames, RAMP_FRAMES) frames.
//   o_out  delivers one request per frame: out_left, out_right (Q1.23, saturated).
//          In mono mode out_left is the average of both gained samples and
//          out_right is zero.
//   i_cfg  writes register addr with data: 0 target gain (Q3.16, clamped to
//          MAX_GAIN), 1 hold frames, 2 release coefficient (Q0.24), 3 mono.
//          It is always ready; write only while no frame is in flight.
// Timing: one frame at a time; the next frame is taken only after the result is
//   loaded into the output register. The 27-step bit-serial reciprocal of the
//   frame peak takes most of the time spent on each frame.
// Reset (i_rst_n low, synchronous) restores the register defaults, unity gain,
//   a ceiling at MAX_GAIN, no ramp and no hold, and empties the output register.
// When the receiver stalls, the finished frame waits in the output register and
//   the next frame is processed up to the output step, where it waits its turn.
module stereo_gain_ramp_peak_limiter_top #(
    parameter int MAX_GAIN    = 4,
    parameter int RAMP_FRAMES = 128,
    parameter int MAX_BLOCK   = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sgpl_in_if.sink         i_in,
    sgpl_out_if.source      o_out,
    sgpl_cfg_if.sink        i_cfg
);

    sgpl_pkg::t_dp_cmd      w_cmd;
    sgpl_pkg::t_dp_status   w_status;

    // Register writes are taken at any time
    assign i_cfg.ready = 1'b1;

    sgpl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    sgpl_dp #(
        .MAX_GAIN    (MAX_GAIN),
        .RAMP_FRAMES (RAMP_FRAMES),
        .MAX_BLOCK   (MAX_BLOCK)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_left_sample  (i_in.left_sample),
        .i_right_sample (i_in.right_sample),
        .i_block_start  (i_in.block_start),
        .i_block_frames (i_in.block_frames),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_addr     (i_cfg.addr),
        .i_cfg_data     (i_cfg.data),
        .o_out_left     (o_out.out_left),
        .o_out_right    (o_out.out_right)
    );

endmodule

### hdl/sgpl_div.sv
// Restoring divider, one quotient bit per step, for the datapath.
// Depends on sgpl_pkg for widths.
module sgpl_div (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic                            i_step,
    input  logic [sgpl_pkg::DEN_W-1:0]      i_rem_init,
    input  logic [sgpl_pkg::QUO_W-1:0]      i_quo_init,
    input  logic [sgpl_pkg::DEN_W-1:0]      i_den,
    output logic [sgpl_pkg::QUO_W-1:0]      o_quo
);

    logic [sgpl_pkg::DEN_W-1:0] r_rem;
    logic [sgpl_pkg::DEN_W-1:0] r_den;
    logic [sgpl_pkg::QUO_W-1:0] r_quo;
    logic [sgpl_pkg::DEN_W:0]   w_trial;
    logic                       w_ge;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign w_trial = {r_rem, r_quo[sgpl_pkg::QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_rem_init;
            r_quo <= i_quo_init;
            r_den <= i_den;
        end else if (i_step) begin
            r_rem <= w_ge ? sgpl_pkg::DEN_W'(w_trial - {1'b0, r_den})
                          : w_trial[sgpl_pkg::DEN_W-1:0];
            r_quo <= {r_quo[sgpl_pkg::QUO_W-2:0], w_ge};
        end
    end

    assign o_quo = r_quo;

endmodule

### hdl/sgpl_dp.sv
// Datapath: gain ramp, stereo-linked ceiling, release, gain multiply and rounding.
// Depends on sgpl_pkg and instantiates sgpl_div twice.
module sgpl_dp #(
    parameter int MAX_GAIN    = 4,
    parameter int RAMP_FRAMES = 128,
    parameter int MAX_BLOCK   = 4096
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  sgpl_pkg::t_dp_cmd                       i_cmd,
    output sgpl_pkg::t_dp_status                    o_status,
    input  logic signed [sgpl_pkg::SAMPLE_W-1:0]    i_left_sample,
    input  logic signed [sgpl_pkg::SAMPLE_W-1:0]    i_right_sample,
    input  logic                                    i_block_start,
    input  logic [sgpl_pkg::FRAMES_W-1:0]           i_block_frames,
    input  logic                                    i_cfg_we,
    input  logic [sgpl_pkg::ADDR_W-1:0]             i_cfg_addr,
    input  logic [sgpl_pkg::DATA_W-1:0]             i_cfg_data,
    output logic signed [sgpl_pkg::SAMPLE_W-1:0]    o_out_left,
    output logic signed [sgpl_pkg::SAMPLE_W-1:0]    o_out_right
);

    localparam logic [sgpl_pkg::GAIN_W-1:0] GAIN_MAX_Q16 = sgpl_pkg::GAIN_W'(MAX_GAIN * 65536);
    localparam logic [sgpl_pkg::CEIL_W-1:0] CEIL_MAX_Q24 =
        sgpl_pkg::CEIL_W'(MAX_GAIN * 16777216);
    localparam logic [sgpl_pkg::CEIL_W-1:0] CEIL_MIN_Q24 = 27'd16777216;
    localparam logic [16:0] MAX_BLOCK_C   = 17'(MAX_BLOCK);
    localparam logic [16:0] RAMP_FRAMES_C = 17'(RAMP_FRAMES);

    // Round to nearest (ties away from zero), shift by 24 or 25, saturate to 24 bits
    function automatic logic [23:0] rnd_sat(input logic signed [52:0] v, input logic half);
        logic [52:0] m;
        logic [52:0] q;
        logic [23:0] r;
        m = v[52] ? (~v + 53'd1) : v;
        if (half) begin
            q = (m + 53'h1000000) >> 25;
        end else begin
            q = (m + 53'h0800000) >> 24;
        end
        if (v[52]) begin
            r = (q >= 53'h800000) ? 24'h800000 : 24'(24'd0 - q[23:0]);
        end else begin
            r = (q > 53'h7FFFFF) ? 24'h7FFFFF : q[23:0];
        end
        return r;
    endfunction

    // Magnitude of a signed sample; the most negative value gives 2^23
    function automatic logic [23:0] abs24(input logic signed [23:0] s);
        return s[23] ? 24'(~s + 24'd1) : s;
    endfunction

    // Configuration registers
    logic [sgpl_pkg::GAIN_W-1:0]    r_target_gain;
    logic [sgpl_pkg::HOLD_W-1:0]    r_hold_frames;
    logic [sgpl_pkg::COEF_W-1:0]    r_release_coeff;
    logic                           r_mono_output;

    // Limiter state
    logic [sgpl_pkg::GAIN_W-1:0]        r_cur_gain;
    logic signed [sgpl_pkg::STEP_W-1:0] r_gain_step;
    logic [sgpl_pkg::RAMP_W-1:0]        r_ramp_left;
    logic [sgpl_pkg::CEIL_W-1:0]        r_gain_ceiling;
    logic [sgpl_pkg::HOLD_W-1:0]        r_hold_left;
    logic [sgpl_pkg::CNT_W-1:0]         r_div_cnt;

    // Per-frame working registers
    logic signed [sgpl_pkg::SAMPLE_W-1:0]   r_left;
    logic signed [sgpl_pkg::SAMPLE_W-1:0]   r_right;
    logic                                   r_bstart;
    logic [sgpl_pkg::FRAMES_W-1:0]          r_bframes;
    logic [sgpl_pkg::RAMP_W-1:0]            r_ramp;
    logic                                   r_diff_neg;
    logic                                   r_big;
    logic                                   r_rel;
    logic [sgpl_pkg::CEIL_W-1:0]            r_rdiff;
    logic signed [52:0]                     r_prod;
    logic signed [52:0]                     r_pl;
    logic [51:0]                            r_acc;
    logic signed [sgpl_pkg::SAMPLE_W-1:0]   r_out_left;
    logic signed [sgpl_pkg::SAMPLE_W-1:0]   r_out_right;

    // Prep stage signals
    logic [sgpl_pkg::SAMPLE_W-1:0]  w_mag_l;
    logic [sgpl_pkg::SAMPLE_W-1:0]  w_mag_r;
    logic [sgpl_pkg::SAMPLE_W-1:0]  w_peak;
    logic [26:0]                    w_peak_scaled;
    logic [16:0]                    w_frames;
    logic [sgpl_pkg::RAMP_W-1:0]    w_ramp;
    logic signed [sgpl_pkg::STEP_W-1:0] w_gdiff;
    logic [sgpl_pkg::GAIN_W-1:0]    w_gdiff_mag;

    // Divider results
    logic [sgpl_pkg::QUO_W-1:0]     w_ceil_quo;
    logic [sgpl_pkg::QUO_W-1:0]     w_step_quo;

    // Update stage signals
    logic signed [sgpl_pkg::STEP_W-1:0] w_new_step;
    logic signed [sgpl_pkg::STEP_W-1:0] w_eff_step;
    logic [sgpl_pkg::RAMP_W-1:0]        w_eff_ramp;
    logic [sgpl_pkg::RAMP_W-1:0]        w_ramp_dec;
    logic signed [20:0]                 w_gain_sum;
    logic [sgpl_pkg::GAIN_W-1:0]        w_gain_clamp;
    logic [sgpl_pkg::CEIL_W-1:0]        w_ceiling;

    // Multiplier signals
    logic [sgpl_pkg::CEIL_W-1:0]    w_gain_q24;
    logic [sgpl_pkg::CEIL_W-1:0]    w_applied;
    logic signed [24:0]             w_mul_a;
    logic signed [27:0]             w_mul_b;
    logic signed [52:0]             w_prod;
    logic signed [52:0]             w_mono_sum;

    // Frame peak, ceiling range check, ramp length, gain difference
    assign w_mag_l       = abs24(r_left);
    assign w_mag_r       = abs24(r_right);
    assign w_peak        = (w_mag_l > w_mag_r) ? w_mag_l : w_mag_r;
    assign w_peak_scaled = 27'(w_peak) * 27'(MAX_GAIN);

    always_comb begin
        w_frames = 17'(r_bframes);
        if (w_frames > MAX_BLOCK_C) begin
            w_frames = MAX_BLOCK_C;
        end
        if (w_frames == 17'd0) begin
            w_frames = 17'd1;
        end
        w_ramp = (w_frames < RAMP_FRAMES_C) ? w_frames[sgpl_pkg::RAMP_W-1:0]
                                            : RAMP_FRAMES_C[sgpl_pkg::RAMP_W-1:0];
    end

    assign w_gdiff     = $signed({1'b0, r_target_gain}) - $signed({1'b0, r_cur_gain});
    assign w_gdiff_mag = w_gdiff[19] ? 19'(~w_gdiff + 20'd1) : w_gdiff[18:0];

    // Reciprocal of the peak: 2^47 / peak, starting from remainder 2^20
    sgpl_div u_ceil_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.prep),
        .i_step     (i_cmd.div_step),
        .i_rem_init (24'h100000),
        .i_quo_init ('0),
        .i_den      (w_peak),
        .o_quo      (w_ceil_quo)
    );

    // Ramp step: |target - gain| / ramp length
    sgpl_div u_step_div (
        .i_clk      (i_clk),
        .i_load     (i_cmd.prep),
        .i_step     (i_cmd.div_step),
        .i_rem_init ('0),
        .i_quo_init (sgpl_pkg::QUO_W'(w_gdiff_mag)),
        .i_den      (sgpl_pkg::DEN_W'(w_ramp)),
        .o_quo      (w_step_quo)
    );

    assign o_status.div_done = (r_div_cnt == sgpl_pkg::CNT_W'(sgpl_pkg::DIV_STEPS - 1));

    // Ramp and ceiling decisions for this frame
    assign w_new_step = r_diff_neg ? $signed(20'd0 - w_step_quo[19:0]) : $signed(w_step_quo[19:0]);
    assign w_eff_step = r_bstart ? w_new_step : r_gain_step;
    assign w_eff_ramp = r_bstart ? r_ramp : r_ramp_left;
    assign w_ramp_dec = w_eff_ramp - 8'd1;
    assign w_gain_sum = $signed({2'b00, r_cur_gain}) + $signed({w_eff_step[19], w_eff_step});

    always_comb begin
        if (w_gain_sum < 0) begin
            w_gain_clamp = '0;
        end else if (w_gain_sum > $signed({2'b00, GAIN_MAX_Q16})) begin
            w_gain_clamp = GAIN_MAX_Q16;
        end else begin
            w_gain_clamp = w_gain_sum[18:0];
        end
    end

    assign w_ceiling = r_big ? w_ceil_quo : CEIL_MAX_Q24;

    // Shared multiplier operands
    assign w_gain_q24 = {r_cur_gain, 8'd0};
    assign w_applied  = (w_gain_q24 > r_gain_ceiling) ? r_gain_ceiling : w_gain_q24;

    always_comb begin
        if (i_cmd.rel_lo || i_cmd.rel_hi) begin
            w_mul_a = $signed({1'b0, r_release_coeff});
        end else if (i_cmd.mul_left) begin
            w_mul_a = $signed({r_left[23], r_left});
        end else begin
            w_mul_a = $signed({r_right[23], r_right});
        end
        if (i_cmd.rel_lo) begin
            w_mul_b = $signed({14'd0, r_rdiff[13:0]});
        end else if (i_cmd.rel_hi) begin
            w_mul_b = $signed({15'd0, r_rdiff[26:14]});
        end else begin
            w_mul_b = $signed({1'b0, w_applied});
        end
    end

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_mono_sum = r_pl + r_prod;

    // Configuration writes and limiter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_gain   <= sgpl_pkg::TARGET_GAIN_RST;
            r_hold_frames   <= sgpl_pkg::HOLD_FRAMES_RST;
            r_release_coeff <= sgpl_pkg::RELEASE_COEFF_RST;
            r_mono_output   <= 1'b0;
            r_cur_gain      <= sgpl_pkg::TARGET_GAIN_RST;
            r_gain_step     <= '0;
            r_ramp_left     <= '0;
            r_gain_ceiling  <= CEIL_MAX_Q24;
            r_hold_left     <= '0;
            r_div_cnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    sgpl_pkg::REG_TARGET_GAIN: begin
                        r_target_gain <= (i_cfg_data[18:0] > GAIN_MAX_Q16) ? GAIN_MAX_Q16
                                                                           : i_cfg_data[18:0];
                    end
                    sgpl_pkg::REG_HOLD_FRAMES: begin
                        r_hold_frames <= i_cfg_data[15:0];
                    end
                    sgpl_pkg::REG_RELEASE_COEFF: begin
                        r_release_coeff <= i_cfg_data;
                    end
                    sgpl_pkg::REG_MONO_OUTPUT: begin
                        r_mono_output <= i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end

            // Advance the divider step count
            if (i_cmd.prep) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 5'd1;
            end

            // Ramp the gain; attack or hold the ceiling
            if (i_cmd.update) begin
                r_gain_step <= w_eff_step;
                if (w_eff_ramp != '0) begin
                    r_ramp_left <= w_ramp_dec;
                    r_cur_gain  <= (w_ramp_dec == '0) ? r_target_gain : w_gain_clamp;
                end else begin
                    r_ramp_left <= '0;
                end
                if (w_ceiling <= r_gain_ceiling) begin
                    r_gain_ceiling <= w_ceiling;
                    r_hold_left    <= r_hold_frames;
                end else if (r_hold_left != '0) begin
                    r_hold_left <= r_hold_left - 16'd1;
                end
            end

            // Release the ceiling by the rounded-up fraction
            if (i_cmd.rel_commit && r_rel) begin
                r_gain_ceiling <= r_gain_ceiling + r_acc[50:24];
            end
        end
    end

    // Frame working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_left    <= i_left_sample;
            r_right   <= i_right_sample;
            r_bstart  <= i_block_start;
            r_bframes <= i_block_frames;
        end
        if (i_cmd.prep) begin
            r_ramp     <= w_ramp;
            r_diff_neg <= w_gdiff[19];
            r_big      <= w_peak_scaled > 27'h800000;
        end
        if (i_cmd.update) begin
            r_rel   <= (w_ceiling > r_gain_ceiling) && (r_hold_left == '0);
            r_rdiff <= w_ceiling - r_gain_ceiling;
        end
        if (i_cmd.rel_lo || i_cmd.rel_hi || i_cmd.mul_left || i_cmd.mul_right) begin
            r_prod <= w_prod;
        end
        if (i_cmd.rel_hi) begin
            r_acc <= 52'(r_prod[37:0]) + 52'hFFFFFF;
        end
        if (i_cmd.rel_sum) begin
            r_acc <= r_acc + 52'({r_prod[37:0], 14'd0});
        end
        if (i_cmd.mul_right) begin
            r_pl <= r_prod;
        end
        if (i_cmd.load_out) begin
            if (r_mono_output) begin
                r_out_left  <= rnd_sat(w_mono_sum, 1'b1);
                r_out_right <= '0;
            end else begin
                r_out_left  <= rnd_sat(r_pl, 1'b0);
                r_out_right <= rnd_sat(r_prod, 1'b0);
            end
        end
    end

    assign o_out_left  = r_out_left;
    assign o_out_right = r_out_right;

    // Gain stays within its clamp range
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_gain <= GAIN_MAX_Q16)
        else $error("current gain above maximum");

    // Ceiling stays between unity and the maximum gain
    a_ceil_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_gain_ceiling >= CEIL_MIN_Q24) && (r_gain_ceiling <= CEIL_MAX_Q24))
        else $error("gain ceiling out of range");

    // A release never lowers the ceiling
    a_rel_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rel_commit && r_rel) |=> (r_gain_ceiling >= $past(r_gain_ceiling)))
        else $error("release lowered the ceiling");

endmodule

### hdl/sgpl_ctrl.sv
// Controller: sequences one frame through prep, division, update, release,
// multiply and output; owns the channel handshakes. Depends on sgpl_pkg.
module sgpl_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output sgpl_pkg::t_dp_cmd       o_cmd,
    input  sgpl_pkg::t_dp_status    i_status
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_DIV  = 4'd2;
    localparam logic [3:0] S_UPD  = 4'd3;
    localparam logic [3:0] S_RL   = 4'd4;
    localparam logic [3:0] S_RH   = 4'd5;
    localparam logic [3:0] S_RS   = 4'd6;
    localparam logic [3:0] S_RC   = 4'd7;
    localparam logic [3:0] S_ML   = 4'd8;
    localparam logic [3:0] S_MR   = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Decode commands and the next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_RL;
            end
            S_RL: begin
                o_cmd.rel_lo = 1'b1;
                n_state      = S_RH;
            end
            S_RH: begin
                o_cmd.rel_hi = 1'b1;
                n_state      = S_RS;
            end
            S_RS: begin
                o_cmd.rel_sum = 1'b1;
                n_state       = S_RC;
            end
            S_RC: begin
                o_cmd.rel_commit = 1'b1;
                n_state          = S_ML;
            end
            S_ML: begin
                o_cmd.mul_left = 1'b1;
                n_state        = S_MR;
            end
            S_MR: begin
                o_cmd.mul_right = 1'b1;
                n_state         = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until the request is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output overwritten while stalled");

    // An accepted request always enters preparation
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_PREP))
        else $error("accepted request did not start");

    // Division runs until the datapath reports the last step
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_status.div_done) |=> (r_state == S_DIV))
        else $error("division left early");

endmodule

### verif/testbench.sv
// Self-checking testbench for the stereo gain ramp peak limiter top level.
// Depends on sgpl_pkg and the channel interfaces in sgpl_if; drives frames and register
// writes, predicts each limited frame and checks every output request field by field.
module testbench;

    localparam int MAX_GAIN    = 4;
    localparam int RAMP_FRAMES = 128;
    localparam int MAX_BLOCK   = 4096;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 95;

    localparam logic [sgpl_pkg::GAIN_W-1:0] GAIN_MAX_Q16 = sgpl_pkg::GAIN_W'(MAX_GAIN << 16);
    localparam logic [sgpl_pkg::CEIL_W-1:0] CEIL_MAX_Q24 = sgpl_pkg::CEIL_W'(MAX_GAIN << 24);

    typedef struct {
        logic signed [sgpl_pkg::SAMPLE_W-1:0] left_sample;
        logic signed [sgpl_pkg::SAMPLE_W-1:0] right_sample;
        logic                                 block_start;
        logic [sgpl_pkg::FRAMES_W-1:0]        block_frames;
    } t_frame;

    typedef struct {
        logic signed [sgpl_pkg::SAMPLE_W-1:0] out_left;
        logic signed [sgpl_pkg::SAMPLE_W-1:0] out_right;
    } t_limited;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sgpl_in_if  in_ch();
    sgpl_out_if out_ch();
    sgpl_cfg_if cfg_ch();

    stereo_gain_ramp_peak_limiter_top #(
        .MAX_GAIN(MAX_GAIN),
        .RAMP_FRAMES(RAMP_FRAMES),
        .MAX_BLOCK(MAX_BLOCK)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg(cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // Limiter model: register copies and state
    logic [sgpl_pkg::GAIN_W-1:0]        lim_target      = sgpl_pkg::TARGET_GAIN_RST;
    logic [sgpl_pkg::HOLD_W-1:0]        lim_hold_frames = sgpl_pkg::HOLD_FRAMES_RST;
    logic [sgpl_pkg::COEF_W-1:0]        lim_release     = sgpl_pkg::RELEASE_COEFF_RST;
    logic                               lim_mono        = 1'b0;
    logic [sgpl_pkg::GAIN_W-1:0]        gain_now        = sgpl_pkg::TARGET_GAIN_RST;
    logic signed [sgpl_pkg::STEP_W-1:0] gain_inc        = '0;
    logic [sgpl_pkg::RAMP_W-1:0]        ramp_count      = '0;
    logic [sgpl_pkg::CEIL_W-1:0]        ceiling_now     = CEIL_MAX_Q24;
    logic [sgpl_pkg::HOLD_W-1:0]        hold_count      = '0;

    t_frame   frames_to_send[$];
    t_limited limited_frames[$];
    t_frame   frame_on_bus;
    bit       in_taken = 1'b0;
    bit       calm = 1'b0;
    bit       hold_req = 1'b0;
    bit       hold_done = 1'b0;
    int       tx_gap = 0;
    int       rx_gap = 0;
    int       rx_hold = 0;
    int       mismatches = 0;
    int       cycles = 0;

    // Round to nearest (ties away from zero), then saturate to the sample range
    function automatic logic signed [sgpl_pkg::SAMPLE_W-1:0] round_sat(longint v, int sh);
        longint m;
        bit     neg;
        neg = v < 0;
        m = ((neg ? -v : v) + (longint'(1) <<< (sh - 1))) >>> sh;
        if (m > (longint'(1) <<< 24)) m = longint'(1) <<< 24;
        if (neg) m = -m;
        if (m > 8388607) m = 8388607;
        if (m < -8388608) m = -8388608;
        return sgpl_pkg::SAMPLE_W'(m);
    endfunction

    function automatic void apply_reg(logic [sgpl_pkg::ADDR_W-1:0] idx,
                                      logic [sgpl_pkg::DATA_W-1:0] val);
        case (idx)
            sgpl_pkg::REG_TARGET_GAIN: begin
                lim_target = (val[sgpl_pkg::GAIN_W-1:0] > GAIN_MAX_Q16) ? GAIN_MAX_Q16
                                                                        : val[sgpl_pkg::GAIN_W-1:0];
            end
            sgpl_pkg::REG_HOLD_FRAMES: lim_hold_frames = val[sgpl_pkg::HOLD_W-1:0];
            sgpl_pkg::REG_RELEASE_COEFF: lim_release = val[sgpl_pkg::COEF_W-1:0];
            sgpl_pkg::REG_MONO_OUTPUT: lim_mono = val[0];
            default: ;
        endcase
    endfunction

    // Advance the ramp and the ceiling by one frame and return the limited frame
    function automatic t_limited limit_frame(t_frame f);
        longint   l, r, frames, ramp, g, peak, ceil_new, diff, inc, applied;
        t_limited res;
        l = longint'(f.left_sample);
        r = longint'(f.right_sample);
        if (f.block_start) begin
            frames = longint'(f.block_frames);
            if (frames > MAX_BLOCK) frames = MAX_BLOCK;
            if (frames == 0) frames = 1;
            ramp = (frames < RAMP_FRAMES) ? frames : RAMP_FRAMES;
            gain_inc = sgpl_pkg::STEP_W'((longint'(lim_target) - longint'(gain_now)) / ramp);
            ramp_count = sgpl_pkg::RAMP_W'(ramp);
        end
        if (ramp_count > 0) begin
            ramp_count = ramp_count - 1'b1;
            if (ramp_count == 0) begin
                gain_now = lim_target;
            end else begin
                g = longint'(gain_now) + longint'(gain_inc);
                if (g < 0) g = 0;
                if (g > GAIN_MAX_Q16) g = GAIN_MAX_Q16;
                gain_now = sgpl_pkg::GAIN_W'(g);
            end
        end
        // Stereo-linked ceiling: instant attack, hold countdown, one-pole release
        peak = (l < 0 ? -l : l);
        if ((r < 0 ? -r : r) > peak) peak = (r < 0 ? -r : r);
        if (peak * MAX_GAIN > (longint'(1) <<< 23))
            ceil_new = (longint'(1) <<< 47) / peak;
        else
            ceil_new = longint'(CEIL_MAX_Q24);
        if (ceil_new <= longint'(ceiling_now)) begin
            ceiling_now = sgpl_pkg::CEIL_W'(ceil_new);
            hold_count = lim_hold_frames;
        end else if (hold_count > 0) begin
            hold_count = hold_count - 1'b1;
        end else begin
            diff = ceil_new - longint'(ceiling_now);
            inc = (diff * longint'(lim_release) + 64'hFFFFFF) >>> 24;
            ceiling_now = sgpl_pkg::CEIL_W'(longint'(ceiling_now) + inc);
        end
        applied = longint'(gain_now) << 8;
        if (applied > longint'(ceiling_now)) applied = longint'(ceiling_now);
        if (lim_mono) begin
            res.out_left = round_sat(l * applied + r * applied, 25);
            res.out_right = '0;
        end else begin
            res.out_left = round_sat(l * applied, 24);
            res.out_right = round_sat(r * applied, 24);
        end
        return res;
    endfunction

    function automatic void add_frame(logic signed [sgpl_pkg::SAMPLE_W-1:0] l,
                                      logic signed [sgpl_pkg::SAMPLE_W-1:0] r,
                                      logic start, logic [sgpl_pkg::FRAMES_W-1:0] frames);
        t_frame f;
        f.left_sample = l;
        f.right_sample = r;
        f.block_start = start;
        f.block_frames = frames;
        frames_to_send.push_back(f);
    endfunction

    function automatic logic signed [sgpl_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(sgpl_pkg::SAMPLE_W-1){1'b0}}};
            1: return {1'b0, {(sgpl_pkg::SAMPLE_W-1){1'b1}}};
            2: return '0;
            3, 4: return sgpl_pkg::SAMPLE_W'(int'($urandom_range(0, 4194304)) - 2097152);
            5: return sgpl_pkg::SAMPLE_W'(int'($urandom_range(0, 65536)) - 32768);
            default: return sgpl_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed blocks with random content, the rest stray frames
    function automatic void add_random_frames(int count);
        int made, len, i;
        logic [sgpl_pkg::FRAMES_W-1:0] odd_len;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 9) < 8) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 200)
                                                  : $urandom_range(1, 40);
                for (i = 0; i < len && made < count; i++) begin
                    add_frame(pick_sample(), pick_sample(), i == 0,
                              (i == 0) ? sgpl_pkg::FRAMES_W'(len)
                                       : sgpl_pkg::FRAMES_W'($urandom));
                    made++;
                end
            end else begin
                case ($urandom_range(0, 3))
                    0: odd_len = '0;
                    1: odd_len = sgpl_pkg::FRAMES_W'($urandom_range(MAX_BLOCK + 1, 8191));
                    default: odd_len = sgpl_pkg::FRAMES_W'($urandom);
                endcase
                add_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)), odd_len);
                made++;
            end
        end
    endfunction

    // Register write; the caller lowers valid after its last write
    task automatic write_reg(input logic [sgpl_pkg::ADDR_W-1:0] idx,
                             input logic [sgpl_pkg::DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    task automatic write_all(input logic [sgpl_pkg::DATA_W-1:0] tgt,
                             input logic [sgpl_pkg::DATA_W-1:0] hold,
                             input logic [sgpl_pkg::DATA_W-1:0] rel,
                             input logic [sgpl_pkg::DATA_W-1:0] mono);
        write_reg(sgpl_pkg::REG_TARGET_GAIN, tgt);
        write_reg(sgpl_pkg::REG_HOLD_FRAMES, hold);
        write_reg(sgpl_pkg::REG_RELEASE_COEFF, rel);
        write_reg(sgpl_pkg::REG_MONO_OUTPUT, mono);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold the stimulus until every frame is sent and every result is back
    task automatic wait_idle();
        while (frames_to_send.size() != 0 || in_ch.valid || limited_frames.size() != 0)
            @(posedge i_clk);
    endtask

    // Cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Input side: record accepted requests and predict their results
    always @(posedge i_clk) begin
        in_taken = in_ch.valid && in_ch.ready;
        if (in_taken) limited_frames.push_back(limit_frame(frame_on_bus));
    end

    // Drive frames with random idle bursts
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.left_sample <= '0;
            in_ch.right_sample <= '0;
            in_ch.block_start <= 1'b0;
            in_ch.block_frames <= '0;
        end else if (in_ch.valid && !in_taken) begin
            // hold the request until taken
        end else if (tx_gap > 0) begin
            in_ch.valid <= 1'b0;
            tx_gap--;
        end else if (frames_to_send.size() != 0) begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                tx_gap = $urandom_range(0, 4);
                in_ch.valid <= 1'b0;
            end else begin
                frame_on_bus = frames_to_send.pop_front();
                in_ch.left_sample <= frame_on_bus.left_sample;
                in_ch.right_sample <= frame_on_bus.right_sample;
                in_ch.block_start <= frame_on_bus.block_start;
                in_ch.block_frames <= frame_on_bus.block_frames;
                in_ch.valid <= 1'b1;
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Output ready: long hold-off on request, always ready in the calm phase, otherwise random stall bursts
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            out_ch.ready <= 1'b0;
            rx_hold--;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rx_hold = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else if (calm) begin
            out_ch.ready <= 1'b1;
        end else if (rx_gap > 0) begin
            out_ch.ready <= 1'b0;
            rx_gap--;
        end else if ($urandom_range(0, 4) == 0) begin
            rx_gap = $urandom_range(0, 4);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each output request with the oldest prediction
    always @(posedge i_clk) begin
        t_limited want;
        if (out_ch.valid && out_ch.ready) begin
            if (limited_frames.size() == 0) begin
                $display("%0t: unexpected output left %0d right %0d", $time,
                         out_ch.out_left, out_ch.out_right);
                mismatches++;
            end else begin
                want = limited_frames.pop_front();
                if (out_ch.out_left !== want.out_left) begin
                    $display("%0t: out_left expected %0d, got %0d", $time,
                             want.out_left, out_ch.out_left);
                    mismatches++;
                end
                if (out_ch.out_right !== want.out_right) begin
                    $display("%0t: out_right expected %0d, got %0d", $time,
                             want.out_right, out_ch.out_right);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        int k;
        logic [sgpl_pkg::DATA_W-1:0] tgt, hold, rel;
        cfg_ch.valid = 1'b0;
        cfg_ch.addr = '0;
        cfg_ch.data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: zero block length, sample extremes, ceiling threshold
        add_frame(24'sd0, 24'sd0, 1'b1, 13'd0);
        add_frame(24'sh7FFFFF, -24'sh800000, 1'b0, 13'd0);
        add_frame(-24'sh800000, 24'sh7FFFFF, 1'b0, 13'h1FFF);
        add_frame(24'sd2097152, -24'sd2097152, 1'b0, 13'd0);
        add_frame(24'sd2097153, 24'sd1, 1'b0, 13'd0);
        add_frame(-24'sd1, 24'sd1, 1'b0, 13'd0);
        wait_idle();

        // Clamped target, no hold, fastest release: ramps, restart during a ramp
        write_all(24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0);
        add_frame(24'sd1000, -24'sd1000, 1'b1, 13'h1FFF);
        for (k = 0; k < 4; k++) add_frame(24'sd3000000, -24'sd5000, 1'b0, 13'd0);
        add_frame(24'sd123456, 24'sd654321, 1'b1, 13'd5);
        for (k = 0; k < 5; k++) add_frame(-24'sd40000, 24'sd70000, 1'b0, 13'd0);
        add_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 13'd128);
        add_frame(24'sd500000, -24'sd8000, 1'b1, 13'd4096);
        wait_idle();

        // Target change without a block start, longest hold, no release, mono
        write_all(24'd0, 24'hFFFFFF, 24'd0, 24'd1);
        add_frame(24'sh7FFFFF, 24'sh7FFFFF, 1'b0, 13'd0);
        add_frame(-24'sh800000, -24'sh800000, 1'b0, 13'd0);
        add_frame(24'sd100000, 24'sd100001, 1'b1, 13'd1);
        add_frame(24'sd100000, -24'sd100001, 1'b0, 13'd0);
        wait_idle();

        // Random settings and random frames; the last phase runs without idling
        for (k = 0; k < RAND_PHASES; k++) begin
            case ($urandom_range(0, 3))
                0: tgt = 24'd0;
                1: tgt = sgpl_pkg::DATA_W'($urandom);
                default: tgt = sgpl_pkg::DATA_W'($urandom_range(0, 262144));
            endcase
            hold = sgpl_pkg::DATA_W'(($urandom & 32'hFF0000) |
                   (($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 60)));
            rel = ($urandom_range(0, 1) == 0) ? sgpl_pkg::DATA_W'($urandom)
                                              : sgpl_pkg::DATA_W'($urandom_range(0, 20000));
            write_all(tgt, hold, rel, sgpl_pkg::DATA_W'($urandom));
            calm = (k == RAND_PHASES - 1);
            add_random_frames(PHASE_ITEMS);
            if (k == 2) begin
                @(posedge i_clk);
                hold_req = 1'b1;
            end
            wait_idle();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && limited_frames.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
